// ----- hdl/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants
// Request/result payloads, internal command format and datapath widths.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 16;
    localparam int SUM_W     = 52;
    localparam int CNT_W     = 16;
    localparam int NRM_W     = 16;
    localparam int DIF_W     = POS_W + 1;
    localparam int PRD_W     = 2 * DIF_W;
    localparam int CRS_W     = 36;
    localparam int POS_RAM_W = 3 * POS_W;
    localparam int ACC_W     = 3 * SUM_W + CNT_W;
    localparam int HALF_W    = SUM_W / 2;
    localparam int N2_W      = 106;
    localparam int ROOT_W    = 53;
    localparam int QBITS     = 15;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TRI   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_TRI,
        OP_READ,
        OP_READ_NULL
    } t_op;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [CNT_W-1:0]        face_count;
        logic                    degenerate;
    } t_out;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_cmd;

endpackage

// ----- hdl/vertex_normal_accumulator.sv -----
// Requests pass through the registered request queue; the back end then holds
// each: position write, accept only; triangle, accept, three position reads,
// seven multiplier steps, three read-modify-writes; read, accept, latch,
// squaring, 53-step square root, per-axis divisor load and division, output;
// out-of-range read, accept, output. Synchronous active-low reset clears queue
// and sequencer; stores are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator: area-weighted vertex normal engine
// Front end queues checked requests; back end executes them on the stores.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vna_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output vna_pkg::t_out o_rsp
);
    import vna_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    vna_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );
endmodule

// ----- hdl/vna_ram.sv -----
// ----------------------------------------------------------------------------
// vna_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int W = 8,
    parameter int D = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/vna_front.sv -----
// ----------------------------------------------------------------------------
// vna_front: request intake
// Accepts requests, range-checks indexes, drops no-op requests and queues
// commands for the back end in a two-entry FIFO.
// ----------------------------------------------------------------------------
module vna_front #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vna_pkg::t_in   i_req,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output vna_pkg::t_cmd  o_cmd
);
    import vna_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       a_ok, b_ok, c_ok, keep, push, pop;
    t_cmd       cmd;

    assign a_ok = 32'(i_req.index_a) < 32'(VERTEX_COUNT);
    assign b_ok = 32'(i_req.index_b) < 32'(VERTEX_COUNT);
    assign c_ok = 32'(i_req.index_c) < 32'(VERTEX_COUNT);

    always_comb begin
        cmd.index_a = i_req.index_a;
        cmd.index_b = i_req.index_b;
        cmd.index_c = i_req.index_c;
        cmd.pos_x   = i_req.pos_x;
        cmd.pos_y   = i_req.pos_y;
        cmd.pos_z   = i_req.pos_z;
        cmd.op      = OP_WRITE;
        keep        = 1'b0;
        case (i_req.req_type)
            REQ_WRITE: begin
                cmd.op = OP_WRITE;
                keep   = a_ok;
            end
            REQ_TRI: begin
                cmd.op = OP_TRI;
                keep   = a_ok && b_ok && c_ok;
            end
            REQ_READ: begin
                cmd.op = a_ok ? OP_READ : OP_READ_NULL;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- hdl/vna_back.sv -----
// ----------------------------------------------------------------------------
// vna_back: command execution
// Owns the position and accumulator stores. Runs triangle accumulation as a
// sequence of reads, a shared multiplier and three read-modify-writes, and
// reads as squared norm, bit-serial square root and bit-serial division.
// ----------------------------------------------------------------------------
module vna_back #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  vna_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output vna_pkg::t_out  o_rsp
);
    import vna_pkg::*;

    localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int RMW = ROOT_W + 2;
    localparam int ITW = $clog2(ROOT_W);

    typedef enum logic [3:0] {
        S_IDLE, S_PRD, S_MUL, S_RMW_RD, S_RMW_WR,
        S_RLAT, S_SQ, S_SQRT, S_DLD, S_DIV, S_DONE
    } t_state;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [CRS_W-1:0] n
    );
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
        if (t[SUM_W] != t[SUM_W-1]) begin
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return t[SUM_W-1:0];
    endfunction

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [1:0]              r_k;
    logic [1:0]              r_j;
    logic [2:0]              r_mstep;
    logic signed [POS_W-1:0] r_pa [3];
    logic signed [DIF_W-1:0] r_d1 [3];
    logic signed [DIF_W-1:0] r_d2 [3];
    logic signed [PRD_W-1:0] r_prod;
    logic signed [CRS_W-1:0] r_n [3];
    logic [SUM_W-1:0]        r_mag [3];
    logic                    r_neg [3];
    logic [CNT_W-1:0]        r_count;
    logic                    r_degen;
    logic [1:0]              r_axis;
    logic [1:0]              r_part;
    logic                    r_issued;
    logic                    r_pvalid;
    logic [1:0]              r_ppart;
    logic [2*HALF_W-1:0]     r_sq;
    logic [N2_W-1:0]         r_n2;
    logic [ROOT_W-1:0]       r_root;
    logic [RMW-1:0]          r_rem;
    logic [ITW-1:0]          r_it;
    logic [RMW-1:0]          r_div;
    logic [QBITS-1:0]        r_q;
    logic [3:0]              r_dstep;
    logic signed [NRM_W-1:0] r_nrm [3];
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    pos_we, acc_we;
    logic [AW-1:0]           pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [POS_RAM_W-1:0]    pos_wdata, pos_rdata;
    logic [ACC_W-1:0]        acc_wdata, acc_rdata;
    logic [IDX_W-1:0]        corner;
    logic signed [POS_W-1:0] rp [3];
    logic signed [SUM_W-1:0] rs [3];
    logic [CNT_W-1:0]        rc;
    logic signed [DIF_W-1:0] m_a, m_b;
    logic [2:0]              pstep;
    logic [SUM_W-1:0]        msel;
    logic [HALF_W-1:0]       sq_a, sq_b;
    logic [N2_W-1:0]         sq_term;
    logic [RMW+1:0]          sr_t, sr_trial;
    logic                    sr_ge;
    logic                    dv_ge;
    logic [RMW-1:0]          dv_sub;
    logic [QBITS-1:0]        dv_q;

    vna_ram #(.W(POS_RAM_W), .D(VERTEX_COUNT)) u_pos_ram (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    vna_ram #(.W(ACC_W), .D(VERTEX_COUNT)) u_acc_ram (
        .i_clk(i_clk), .i_we(acc_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_raddr(acc_raddr), .o_rdata(acc_rdata)
    );

    assign rp[0] = pos_rdata[3*POS_W-1 -: POS_W];
    assign rp[1] = pos_rdata[2*POS_W-1 -: POS_W];
    assign rp[2] = pos_rdata[POS_W-1:0];
    assign rs[0] = acc_rdata[ACC_W-1 -: SUM_W];
    assign rs[1] = acc_rdata[ACC_W-SUM_W-1 -: SUM_W];
    assign rs[2] = acc_rdata[ACC_W-2*SUM_W-1 -: SUM_W];
    assign rc    = acc_rdata[CNT_W-1:0];

    always_comb begin
        case (r_j)
            2'd0:    corner = r_cmd.index_a;
            2'd1:    corner = r_cmd.index_b;
            default: corner = r_cmd.index_c;
        endcase
    end

    always_comb begin
        pos_we    = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == OP_WRITE);
        pos_waddr = AW'(i_cmd.index_a);
        pos_wdata = {i_cmd.pos_x, i_cmd.pos_y, i_cmd.pos_z};
        if (r_state == S_IDLE) begin
            pos_raddr = AW'(i_cmd.index_a);
        end else if (r_k == 2'd0) begin
            pos_raddr = AW'(r_cmd.index_b);
        end else begin
            pos_raddr = AW'(r_cmd.index_c);
        end
        acc_we    = pos_we || (r_state == S_RMW_WR);
        if (r_state == S_IDLE) begin
            acc_waddr = AW'(i_cmd.index_a);
            acc_raddr = AW'(i_cmd.index_a);
            acc_wdata = '0;
        end else begin
            acc_waddr = AW'(corner);
            acc_raddr = AW'(corner);
            acc_wdata = {sat_add(rs[0], r_n[0]), sat_add(rs[1], r_n[1]),
                         sat_add(rs[2], r_n[2]),
                         (rc == '1) ? rc : rc + CNT_W'(1)};
        end
    end

    // cross product term order: x+ x- y+ y- z+ z-
    always_comb begin
        case (r_mstep)
            3'd0:    begin m_a = r_d1[1]; m_b = r_d2[2]; end
            3'd1:    begin m_a = r_d1[2]; m_b = r_d2[1]; end
            3'd2:    begin m_a = r_d1[2]; m_b = r_d2[0]; end
            3'd3:    begin m_a = r_d1[0]; m_b = r_d2[2]; end
            3'd4:    begin m_a = r_d1[0]; m_b = r_d2[1]; end
            default: begin m_a = r_d1[1]; m_b = r_d2[0]; end
        endcase
        pstep = r_mstep - 3'd1;
    end

    always_comb begin
        msel = r_mag[r_axis];
        case (r_part)
            2'd0:    begin sq_a = msel[SUM_W-1 -: HALF_W]; sq_b = msel[SUM_W-1 -: HALF_W]; end
            2'd1:    begin sq_a = msel[SUM_W-1 -: HALF_W]; sq_b = msel[HALF_W-1:0]; end
            default: begin sq_a = msel[HALF_W-1:0];        sq_b = msel[HALF_W-1:0]; end
        endcase
        case (r_ppart)
            2'd0:    sq_term = N2_W'(r_sq) << (2 * HALF_W);
            2'd1:    sq_term = N2_W'(r_sq) << (HALF_W + 1);
            default: sq_term = N2_W'(r_sq);
        endcase
    end

    always_comb begin
        sr_t     = {r_rem, r_n2[N2_W-1 -: 2]};
        sr_trial = (RMW+2)'({r_root, 2'b01});
        sr_ge    = sr_t >= sr_trial;
        dv_ge    = r_div >= RMW'(r_root);
        dv_sub   = dv_ge ? r_div - RMW'(r_root) : r_div;
        dv_q     = {r_q[QBITS-2:0], dv_ge};
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmd <= i_cmd;
                    r_k   <= 2'd0;
                    r_j   <= 2'd0;
                    if (i_cmd_valid) begin
                        case (i_cmd.op)
                            OP_TRI:  r_state <= S_PRD;
                            OP_READ: r_state <= S_RLAT;
                            OP_READ_NULL: begin
                                for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
                                r_count <= '0;
                                r_degen <= 1'b1;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PRD: begin
                    r_k <= r_k + 2'd1;
                    for (int i = 0; i < 3; i++) begin
                        case (r_k)
                            2'd0:    r_pa[i] <= rp[i];
                            2'd1:    r_d1[i] <= DIF_W'(rp[i]) - DIF_W'(r_pa[i]);
                            default: r_d2[i] <= DIF_W'(rp[i]) - DIF_W'(r_pa[i]);
                        endcase
                    end
                    if (r_k == 2'd2) begin
                        r_mstep <= 3'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= m_a * m_b;
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep != 3'd0) begin
                        r_n[pstep[2:1]] <= pstep[0] ? r_n[pstep[2:1]] - CRS_W'(r_prod)
                                                    : CRS_W'(r_prod);
                    end
                    if (r_mstep == 3'd6) begin
                        r_state <= S_RMW_RD;
                    end
                end
                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end
                S_RMW_WR: begin
                    r_j     <= r_j + 2'd1;
                    r_state <= (r_j == 2'd2) ? S_IDLE : S_RMW_RD;
                end
                S_RLAT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= rs[i][SUM_W-1] ? SUM_W'(-rs[i]) : SUM_W'(rs[i]);
                        r_neg[i] <= rs[i][SUM_W-1];
                        r_nrm[i] <= '0;
                    end
                    r_count  <= rc;
                    r_axis   <= 2'd0;
                    r_part   <= 2'd0;
                    r_issued <= 1'b0;
                    r_pvalid <= 1'b0;
                    r_n2     <= '0;
                    r_root   <= '0;
                    r_rem    <= '0;
                    r_it     <= '0;
                    if (rs[0] == '0 && rs[1] == '0 && rs[2] == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (!r_issued) begin
                        r_sq     <= sq_a * sq_b;
                        r_ppart  <= r_part;
                        r_pvalid <= 1'b1;
                        if (r_part == 2'd2) begin
                            r_part <= 2'd0;
                            r_axis <= r_axis + 2'd1;
                            if (r_axis == 2'd2) begin
                                r_issued <= 1'b1;
                            end
                        end else begin
                            r_part <= r_part + 2'd1;
                        end
                    end else begin
                        r_pvalid <= 1'b0;
                    end
                    if (r_pvalid) begin
                        r_n2 <= r_n2 + sq_term;
                    end
                    if (r_issued && !r_pvalid) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_n2   <= r_n2 << 2;
                    r_rem  <= sr_ge ? RMW'(sr_t - sr_trial) : RMW'(sr_t);
                    r_root <= {r_root[ROOT_W-2:0], sr_ge};
                    r_it   <= r_it + ITW'(1);
                    if (r_it == ITW'(ROOT_W - 1)) begin
                        r_axis  <= 2'd0;
                        r_state <= S_DLD;
                    end
                end
                S_DLD: begin
                    r_div   <= RMW'(r_mag[r_axis]);
                    r_q     <= '0;
                    r_dstep <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_div   <= dv_sub << 1;
                    r_q     <= dv_q;
                    r_dstep <= r_dstep + 4'd1;
                    if (r_dstep == 4'(QBITS - 1)) begin
                        r_nrm[r_axis] <= r_neg[r_axis] ? -NRM_W'(dv_q) : NRM_W'(dv_q);
                        r_axis        <= r_axis + 2'd1;
                        r_state       <= (r_axis == 2'd2) ? S_DONE : S_DLD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.normal_x   <= r_nrm[0];
                        r_out.normal_y   <= r_nrm[1];
                        r_out.normal_z   <= r_nrm[2];
                        r_out.face_count <= r_count;
                        r_out.degenerate <= r_degen;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/sv/vna_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vna_checker: request/result monitor for the vertex normal accumulator
// Tracks vertex positions, normal sums and face counts from accepted
// requests, predicts each read result and compares it field by field.
// ----------------------------------------------------------------------------
module vna_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  vna_pkg::t_in   i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  vna_pkg::t_out  i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import vna_pkg::*;

    localparam longint SUM_HI = 64'sd2251799813685247;
    localparam longint SUM_LO = -SUM_HI - 1;

    longint pos_mem [VERTEX_COUNT_DEF][3];
    longint sum_mem [VERTEX_COUNT_DEF][3];
    int     cnt_mem [VERTEX_COUNT_DEF];
    t_out   normal_q [$];
    int     mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = normal_q.size();

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    function automatic logic [127:0] abs_sum(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [127:0] floor_root(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] cand;
        r = 0;
        for (int b = 53; b >= 0; b--) begin
            cand = r | (128'd1 << b);
            if (cand * cand <= n) r = cand;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_axis(longint s, logic [127:0] root);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] cand;
        num = abs_sum(s) << 14;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            cand = q | (128'd1 << b);
            if (root * cand <= num) q = cand;
        end
        return (s < 0) ? 16'(-q) : 16'(q);
    endfunction

    task automatic add_face(int v, longint nx, longint ny, longint nz);
        sum_mem[v][0] = sat_sum(sum_mem[v][0], nx);
        sum_mem[v][1] = sat_sum(sum_mem[v][1], ny);
        sum_mem[v][2] = sat_sum(sum_mem[v][2], nz);
        if (cnt_mem[v] < 65535) cnt_mem[v]++;
    endtask

    task automatic apply_request(t_in r);
        int a, b, c;
        longint d1 [3];
        longint d2 [3];
        longint nx, ny, nz;
        logic [127:0] n2;
        logic [127:0] root;
        t_out e;
        a = int'(r.index_a);
        b = int'(r.index_b);
        c = int'(r.index_c);
        case (r.req_type)
            REQ_WRITE: begin
                pos_mem[a][0] = longint'(r.pos_x);
                pos_mem[a][1] = longint'(r.pos_y);
                pos_mem[a][2] = longint'(r.pos_z);
                for (int k = 0; k < 3; k++) sum_mem[a][k] = 0;
                cnt_mem[a] = 0;
            end
            REQ_TRI: begin
                for (int k = 0; k < 3; k++) begin
                    d1[k] = pos_mem[b][k] - pos_mem[a][k];
                    d2[k] = pos_mem[c][k] - pos_mem[a][k];
                end
                nx = d1[1] * d2[2] - d1[2] * d2[1];
                ny = d1[2] * d2[0] - d1[0] * d2[2];
                nz = d1[0] * d2[1] - d1[1] * d2[0];
                add_face(a, nx, ny, nz);
                add_face(b, nx, ny, nz);
                add_face(c, nx, ny, nz);
            end
            REQ_READ: begin
                e = '0;
                e.face_count = 16'(cnt_mem[a]);
                e.degenerate = 1'b1;
                if (sum_mem[a][0] != 0 || sum_mem[a][1] != 0 || sum_mem[a][2] != 0) begin
                    n2 = abs_sum(sum_mem[a][0]) * abs_sum(sum_mem[a][0])
                       + abs_sum(sum_mem[a][1]) * abs_sum(sum_mem[a][1])
                       + abs_sum(sum_mem[a][2]) * abs_sum(sum_mem[a][2]);
                    root = floor_root(n2);
                    e.normal_x = unit_axis(sum_mem[a][0], root);
                    e.normal_y = unit_axis(sum_mem[a][1], root);
                    e.normal_z = unit_axis(sum_mem[a][2], root);
                    e.degenerate = 1'b0;
                end
                normal_q.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, t_out exp_v, t_out act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch %s: exp n=(%0d,%0d,%0d) cnt=%0d deg=%0b, got n=(%0d,%0d,%0d) cnt=%0d deg=%0b",
                     $realtime, what, exp_v.normal_x, exp_v.normal_y, exp_v.normal_z,
                     exp_v.face_count, exp_v.degenerate, act_v.normal_x, act_v.normal_y,
                     act_v.normal_z, act_v.face_count, act_v.degenerate);
    endtask

    initial mismatches = 0;

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (normal_q.size() == 0) begin
                    report("unexpected result", '0, i_rsp);
                end else begin
                    e = normal_q.pop_front();
                    if (e.normal_x !== i_rsp.normal_x) report("normal_x", e, i_rsp);
                    else if (e.normal_y !== i_rsp.normal_y) report("normal_y", e, i_rsp);
                    else if (e.normal_z !== i_rsp.normal_z) report("normal_z", e, i_rsp);
                    else if (e.face_count !== i_rsp.face_count) report("face_count", e, i_rsp);
                    else if (e.degenerate !== i_rsp.degenerate) report("degenerate", e, i_rsp);
                end
            end
            if (i_req_valid && i_req_ready) apply_request(i_req);
        end
    end

endmodule

// ----- tb/sv/tb_vertex_normal_accumulator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_accumulator: top-level testbench
// Directed corner requests then random meshes of position writes, triangles
// and reads, with random gaps on both channels; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_vertex_normal_accumulator;
    import vna_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 930;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_req;
    logic  o_valid;
    logic  i_ready;
    t_out  o_rsp;

    int    fail_count;
    int    pending;
    int    idle_mode;
    int    idle_cycles;
    int    n_write, n_tri, n_read, n_skip;
    bit    written [VERTEX_COUNT_DEF];
    int    live_idx [$];
    int    hot_idx [48];

    vertex_normal_accumulator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    vna_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_ready (o_ready),
        .i_req       (i_req),
        .i_rsp_valid (o_valid),
        .i_rsp_ready (i_ready),
        .i_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        if (idle_mode == 0) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // receiver stalls
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = 1'b1;
            @(negedge i_clk);
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
            if (gap_len() > 0) begin
                i_ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("tb_vertex_normal_accumulator: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_in r);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req   = r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic t_in noise_req(logic [1:0] kind);
        t_in r;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        r = noise[$bits(t_in)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    task automatic put_vertex(int idx, int x, int y, int z);
        t_in r;
        r = noise_req(REQ_WRITE);
        r.index_a = IDX_W'(idx);
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        r.pos_z = POS_W'(z);
        if (!written[idx]) live_idx.push_back(idx);
        written[idx] = 1'b1;
        n_write++;
        send(r);
    endtask

    task automatic put_tri(int a, int b, int c);
        t_in r;
        r = noise_req(REQ_TRI);
        r.index_a = IDX_W'(a);
        r.index_b = IDX_W'(b);
        r.index_c = IDX_W'(c);
        n_tri++;
        send(r);
    endtask

    task automatic get_normal(int a);
        t_in r;
        r = noise_req(REQ_READ);
        r.index_a = IDX_W'(a);
        n_read++;
        send(r);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(2) == 0) return $urandom_range(65535) - 32768;
        return $urandom_range(4095) - 2048;
    endfunction

    function automatic int pick_live();
        return live_idx[$urandom_range(live_idx.size() - 1)];
    endfunction

    initial begin
        int r, a, b, c;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_req     = '0;
        idle_mode = 0;
        n_write = 0; n_tri = 0; n_read = 0; n_skip = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, repeated corners, degenerate read, unused type
        put_vertex(0, 32767, -32768, 0);
        put_vertex(1023, -32768, 32767, 32767);
        put_vertex(512, 0, 0, -32768);
        put_vertex(341, 256, 0, 0);
        get_normal(0);
        put_tri(0, 1023, 512);
        put_tri(512, 1023, 0);
        put_tri(0, 0, 341);
        put_tri(341, 341, 341);
        get_normal(0);
        get_normal(1023);
        get_normal(512);
        get_normal(341);
        put_vertex(682, 0, 256, 0);
        put_tri(341, 682, 512);
        get_normal(682);
        put_vertex(0, 1, 1, 1);
        get_normal(0);
        send(noise_req(2'd3));
        n_skip++;
        get_normal(1023);

        for (int k = 0; k < 48; k++) hot_idx[k] = $urandom_range(1023);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 200 == 0) idle_mode = (i / 200) % 2 == 0 ? 1 : 0;
            if (i == 400) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                wait (pending == 0);
            end
            r = $urandom_range(99);
            if (r < 22) begin
                a = ($urandom_range(9) < 3) ? $urandom_range(1023) : hot_idx[$urandom_range(47)];
                put_vertex(a, rand_coord(), rand_coord(), rand_coord());
            end else if (r < 66) begin
                a = pick_live();
                b = ($urandom_range(19) == 0) ? a : pick_live();
                c = ($urandom_range(19) == 0) ? b : pick_live();
                put_tri(a, b, c);
            end else if (r < 96) begin
                get_normal(pick_live());
            end else begin
                send(noise_req(2'd3));
                n_skip++;
            end
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d position writes, %0d triangles, %0d normal reads, %0d unused",
                 n_write, n_tri, n_read, n_skip);
        $display("over %0d distinct vertices with idle gaps on both channels", live_idx.size());
        if (fail_count == 0) begin
            $display("tb_vertex_normal_accumulator: PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_vertex_normal_accumulator: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/vna_pkg.sv
hdl/vna_ram.sv
hdl/vna_front.sv
hdl/vna_back.sv
hdl/vertex_normal_accumulator.sv
tb/sv/vna_checker.sv
tb/sv/tb_vertex_normal_accumulator.sv
